[rtl/core/mcoc_pkg.sv]
// Package for the MAC class / OUI cache unit.
// Holds request codes, class codes, address prefixes and shared types.
// No dependencies.
package mcoc_pkg;

    // Default sizing
    localparam int CACHE_ENTRIES_DEF = 64;
    localparam int VENDOR_BITS_DEF   = 16;

    // Fixed field widths
    localparam int MAC_W    = 48;
    localparam int OUI_W    = 24;
    localparam int HANDLE_W = 16;
    localparam int CLASS_W  = 3;

    // Request kinds (carried in tuser)
    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    // Special address patterns
    localparam logic [MAC_W-1:0] BCAST_MAC     = 48'hFFFF_FFFF_FFFF;
    localparam logic [15:0]      MCAST6_PREFIX = 16'h3333;
    localparam logic [23:0]      MCAST4_PREFIX = 24'h01005E;
    localparam int               LOCAL_BIT     = 1;

    typedef enum logic [CLASS_W-1:0] {
        CLS_BCAST  = 3'd0,
        CLS_MCAST6 = 3'd1,
        CLS_MCAST4 = 3'd2,
        CLS_RANDOM = 3'd3,
        CLS_HIT    = 3'd4,
        CLS_MISS   = 3'd5
    } t_mac_class;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_ctl_state;

    // One classification result
    typedef struct packed {
        t_mac_class            mac_class;
        logic [HANDLE_W-1:0]   vendor_handle;
    } t_result;

endpackage

[rtl/core/mcoc_mem.sv]
// OUI / vendor handle storage: one write port, one read port, registered read data.
// Depends on mcoc_pkg.
module mcoc_mem #(
    parameter int CACHE_ENTRIES = mcoc_pkg::CACHE_ENTRIES_DEF,
    parameter int VENDOR_BITS   = mcoc_pkg::VENDOR_BITS_DEF,
    parameter int IDX_W         = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [IDX_W-1:0]            i_wr_addr,
    input  logic [mcoc_pkg::OUI_W-1:0]  i_wr_oui,
    input  logic [VENDOR_BITS-1:0]      i_wr_vendor,
    input  logic                        i_rd_en,
    input  logic [IDX_W-1:0]            i_rd_addr,
    output logic [mcoc_pkg::OUI_W-1:0]  o_rd_oui,
    output logic [VENDOR_BITS-1:0]      o_rd_vendor
);
    import mcoc_pkg::*;

    logic [OUI_W-1:0]       r_oui_mem    [CACHE_ENTRIES];
    logic [VENDOR_BITS-1:0] r_vendor_mem [CACHE_ENTRIES];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_oui_mem[i_wr_addr]    <= i_wr_oui;
            r_vendor_mem[i_wr_addr] <= i_wr_vendor;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_oui    <= r_oui_mem[i_rd_addr];
            o_rd_vendor <= r_vendor_mem[i_rd_addr];
        end
    end

endmodule

[rtl/core/mcoc_ctl.sv]
// Request controller: classifies special addresses, runs inserts and scans the cache.
// Depends on mcoc_pkg; drives the ports of mcoc_mem.
module mcoc_ctl #(
    parameter int CACHE_ENTRIES = mcoc_pkg::CACHE_ENTRIES_DEF,
    parameter int VENDOR_BITS   = mcoc_pkg::VENDOR_BITS_DEF,
    parameter int IDX_W         = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request side
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  logic                          i_req_func,
    input  logic [mcoc_pkg::MAC_W-1:0]    i_req_mac,
    input  logic [mcoc_pkg::HANDLE_W-1:0] i_req_vendor,
    // result side
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output mcoc_pkg::t_result             o_res,
    // memory ports
    output logic                          o_wr_en,
    output logic [IDX_W-1:0]              o_wr_addr,
    output logic [mcoc_pkg::OUI_W-1:0]    o_wr_oui,
    output logic [VENDOR_BITS-1:0]        o_wr_vendor,
    output logic                          o_rd_en,
    output logic [IDX_W-1:0]              o_rd_addr,
    input  logic [mcoc_pkg::OUI_W-1:0]    i_rd_oui,
    input  logic [VENDOR_BITS-1:0]        i_rd_vendor
);
    import mcoc_pkg::*;

    localparam int FILL_W = $clog2(CACHE_ENTRIES + 1);

    t_ctl_state         r_state, n_state;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [IDX_W-1:0]   r_ptr, n_ptr;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic               r_issue, n_issue;
    logic               r_pend, n_pend;
    logic               r_pend_last, n_pend_last;
    logic [OUI_W-1:0]   r_key, n_key;
    t_result            r_res, n_res;

    logic               w_accept;
    logic               w_idx_last;
    logic [7:0]         w_b0;
    t_mac_class         w_pre_class;
    logic               w_pre_hit;

    assign w_accept   = i_req_valid && o_req_ready;
    assign w_idx_last = ((FILL_W'(r_idx) + FILL_W'(1)) == r_fill);
    assign w_b0       = i_req_mac[MAC_W-1 -: 8];

    // Priority classification of special addresses
    always_comb begin
        w_pre_hit   = 1'b1;
        w_pre_class = CLS_MISS;
        if (i_req_mac == BCAST_MAC) begin
            w_pre_class = CLS_BCAST;
        end else if (i_req_mac[MAC_W-1 -: 16] == MCAST6_PREFIX) begin
            w_pre_class = CLS_MCAST6;
        end else if (i_req_mac[MAC_W-1 -: 24] == MCAST4_PREFIX) begin
            w_pre_class = CLS_MCAST4;
        end else if (w_b0[LOCAL_BIT]) begin
            w_pre_class = CLS_RANDOM;
        end else begin
            w_pre_hit   = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_ptr       <= '0;
            r_issue     <= 1'b0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_ptr       <= n_ptr;
            r_issue     <= n_issue;
            r_pend      <= n_pend;
            r_pend_last <= n_pend_last;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_key <= n_key;
        r_res <= n_res;
    end

    // Next state and outputs
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_ptr       = r_ptr;
        n_idx       = r_idx;
        n_issue     = r_issue;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        n_key       = r_key;
        n_res       = r_res;

        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_ptr;
        o_wr_oui    = i_req_mac[MAC_W-1 -: OUI_W];
        o_wr_vendor = VENDOR_BITS'(i_req_vendor);
        o_rd_en     = 1'b0;
        o_rd_addr   = r_idx;

        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (w_accept) begin
                    if (i_req_func == FUNC_INSERT) begin
                        // write at the round-robin pointer, oldest entry goes first
                        o_wr_en = 1'b1;
                        if (r_fill != FILL_W'(CACHE_ENTRIES)) begin
                            n_fill = r_fill + FILL_W'(1);
                        end
                        if (r_ptr == IDX_W'(CACHE_ENTRIES - 1)) begin
                            n_ptr = '0;
                        end else begin
                            n_ptr = r_ptr + IDX_W'(1);
                        end
                    end else begin
                        n_key             = i_req_mac[MAC_W-1 -: OUI_W];
                        n_res.vendor_handle = '0;
                        n_res.mac_class   = w_pre_class;
                        if (w_pre_hit || (r_fill == '0)) begin
                            n_state = ST_DONE;
                        end else begin
                            n_state     = ST_SCAN;
                            n_idx       = '0;
                            n_issue     = 1'b1;
                            n_pend      = 1'b0;
                            n_pend_last = 1'b0;
                        end
                    end
                end
            end
            ST_SCAN: begin
                // issue one read per cycle, compare the data in the next cycle
                o_rd_en = r_issue;
                n_pend  = r_issue;
                if (r_issue) begin
                    n_idx       = r_idx + IDX_W'(1);
                    n_pend_last = w_idx_last;
                    n_issue     = !w_idx_last;
                end
                if (r_pend) begin
                    if (i_rd_oui == r_key) begin
                        n_res.mac_class     = CLS_HIT;
                        n_res.vendor_handle = HANDLE_W'(i_rd_vendor);
                        n_state             = ST_DONE;
                        n_issue             = 1'b0;
                        n_pend              = 1'b0;
                    end else if (r_pend_last) begin
                        n_res.mac_class = CLS_MISS;
                        n_state         = ST_DONE;
                        n_issue         = 1'b0;
                        n_pend          = 1'b0;
                    end
                end
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

[rtl/core/mac_class_oui_cache_unit.sv]
// MAC address classifier with an OUI cache, top level.
// Depends on mcoc_pkg, mcoc_mem and mcoc_ctl.

// A lookup request classifies a MAC address as broadcast, IPv6 multicast,
// IPv4 multicast or locally administered, and otherwise scans the OUI cache
// from entry 0 upward; the first matching entry returns its vendor handle, else
// the result is a miss. An insert request writes the OUI and handle at a
// round-robin pointer, replacing the oldest entry, and returns nothing. One
// request is in work at a time. A special address or a lookup on an empty cache
// skips the search; a cache search reads up to fill_count entries, at most
// CACHE_ENTRIES, with the single memory read port visiting one entry per cycle.
// A new request is taken while the last result still waits in the output
// register. No clearing pass follows reset.
module mac_class_oui_cache_unit #(
    parameter int CACHE_ENTRIES = mcoc_pkg::CACHE_ENTRIES_DEF,
    parameter int VENDOR_BITS   = mcoc_pkg::VENDOR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [47:0] mac_address, [63:48] new_vendor
    input  logic        s_axis_tuser,   // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [2:0] mac_class, [18:3] vendor_handle, rest zero
);
    import mcoc_pkg::*;

    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

    logic                   w_res_valid;
    logic                   w_res_ready;
    t_result                w_res;
    logic                   w_wr_en;
    logic [IDX_W-1:0]       w_wr_addr;
    logic [OUI_W-1:0]       w_wr_oui;
    logic [VENDOR_BITS-1:0] w_wr_vendor;
    logic                   w_rd_en;
    logic [IDX_W-1:0]       w_rd_addr;
    logic [OUI_W-1:0]       w_rd_oui;
    logic [VENDOR_BITS-1:0] w_rd_vendor;

    logic                   r_out_valid;
    t_result                r_out;

    mcoc_ctl #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .VENDOR_BITS   (VENDOR_BITS),
        .IDX_W         (IDX_W)
    ) u_ctl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .o_req_ready  (s_axis_tready),
        .i_req_func   (s_axis_tuser),
        .i_req_mac    (s_axis_tdata[47:0]),
        .i_req_vendor (s_axis_tdata[63:48]),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (w_res_ready),
        .o_res        (w_res),
        .o_wr_en      (w_wr_en),
        .o_wr_addr    (w_wr_addr),
        .o_wr_oui     (w_wr_oui),
        .o_wr_vendor  (w_wr_vendor),
        .o_rd_en      (w_rd_en),
        .o_rd_addr    (w_rd_addr),
        .i_rd_oui     (w_rd_oui),
        .i_rd_vendor  (w_rd_vendor)
    );

    mcoc_mem #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .VENDOR_BITS   (VENDOR_BITS),
        .IDX_W         (IDX_W)
    ) u_mem (
        .i_clk       (i_clk),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (w_wr_addr),
        .i_wr_oui    (w_wr_oui),
        .i_wr_vendor (w_wr_vendor),
        .i_rd_en     (w_rd_en),
        .i_rd_addr   (w_rd_addr),
        .o_rd_oui    (w_rd_oui),
        .o_rd_vendor (w_rd_vendor)
    );

    // Output register: loads when empty or being drained
    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out.vendor_handle, r_out.mac_class};

    // The controller never offers a result while it takes a request
    a_ready_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_res_valid)
        else $error("request taken while a result is pending");

    // An insert yields no result in the following cycle
    a_insert_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_INSERT))
        |=> !w_res_valid)
        else $error("insert produced a result");

    // A handed-over result shows up on the output
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && w_res_ready) |=> m_axis_tvalid)
        else $error("result lost at output register");

    // Non-hit results carry a zero handle
    a_handle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_out.mac_class != CLS_HIT)) |-> (r_out.vendor_handle == '0))
        else $error("nonzero handle on non-hit result");

endmodule

[tb/testbench.sv]
// Self-checking testbench for mac_class_oui_cache_unit: drives lookup and insert
// requests, predicts each classification result and compares it with the output.
// Depends on mcoc_pkg and the mac_class_oui_cache_unit RTL.
`timescale 1ns / 100ps

module testbench;
    import mcoc_pkg::*;

    localparam int ENTRIES = CACHE_ENTRIES_DEF;
    localparam logic [HANDLE_W-1:0] HANDLE_MASK = HANDLE_W'((64'd1 << VENDOR_BITS_DEF) - 1);
    localparam logic [MAC_W-1:0] LOCAL_MAC_BIT = 48'd1 << (40 + LOCAL_BIT);

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // [47:0] mac_address, [63:48] new_vendor
    logic        s_axis_tuser;   // [0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [2:0] mac_class, [18:3] vendor_handle, rest zero

    // Cache model: contents, fill level and replacement pointer
    logic [OUI_W-1:0]    cache_oui    [ENTRIES];
    logic [HANDLE_W-1:0] cache_vendor [ENTRIES];
    int                  cache_fill;
    int                  cache_wr_ptr;

    t_result     pending_lookups [$];
    int unsigned mismatch_count;
    logic        steady;       // both sides run without idling
    int unsigned hold_len;     // output hold-off requested by a test

    mac_class_oui_cache_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic logic [MAC_W-1:0] random_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic void log_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    // Classify one accepted request against the cache model, or update the model
    function automatic void track_request(logic func, logic [MAC_W-1:0] mac,
                                          logic [HANDLE_W-1:0] vend);
        t_result     res;
        logic [OUI_W-1:0] oui;
        oui = mac[MAC_W-1:MAC_W-OUI_W];
        if (func == FUNC_INSERT) begin
            cache_oui[cache_wr_ptr]    = oui;
            cache_vendor[cache_wr_ptr] = vend & HANDLE_MASK;
            if (cache_fill < ENTRIES)
                cache_fill++;
            cache_wr_ptr = (cache_wr_ptr + 1) % ENTRIES;
        end else begin
            res.vendor_handle = '0;
            if (mac == BCAST_MAC)
                res.mac_class = CLS_BCAST;
            else if (mac[47:32] == MCAST6_PREFIX)
                res.mac_class = CLS_MCAST6;
            else if (oui == MCAST4_PREFIX)
                res.mac_class = CLS_MCAST4;
            else if (mac[40 + LOCAL_BIT])
                res.mac_class = CLS_RANDOM;
            else begin
                // lowest matching index wins
                res.mac_class = CLS_MISS;
                for (int i = 0; i < cache_fill && res.mac_class == CLS_MISS; i++) begin
                    if (cache_oui[i] == oui) begin
                        res.mac_class     = CLS_HIT;
                        res.vendor_handle = cache_vendor[i];
                    end
                end
            end
            pending_lookups.push_back(res);
        end
    endfunction

    // Offer one request; entered and left just after a falling edge
    task automatic send_request(logic func, logic [MAC_W-1:0] mac, logic [HANDLE_W-1:0] vend);
        while (!steady && $urandom_range(0, 99) < 20) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {vend, mac};
        s_axis_tuser  <= func;
        do @(posedge i_clk); while (!s_axis_tready);
        track_request(func, mac, vend);
        @(negedge i_clk);
    endtask

    // Output side: random stalls, plus long hold-offs on request
    initial begin : result_sink
        int unsigned held;
        held          = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_len != 0) begin
                held     = hold_len;
                hold_len = 0;
            end
            if (held != 0) begin
                held--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= steady || ($urandom_range(0, 99) >= 20);
            end
        end
    end

    // Compare each delivered result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_lookups.size() == 0) begin
                log_mismatch($sformatf("unexpected result class %0d handle %h",
                                       m_axis_tdata[2:0], m_axis_tdata[18:3]));
            end else begin
                want = pending_lookups.pop_front();
                if (m_axis_tdata[2:0] !== want.mac_class)
                    log_mismatch($sformatf("class expected %0d got %0d",
                                           want.mac_class, m_axis_tdata[2:0]));
                if (m_axis_tdata[18:3] !== want.vendor_handle)
                    log_mismatch($sformatf("vendor handle expected %h got %h",
                                           want.vendor_handle, m_axis_tdata[18:3]));
                if (m_axis_tdata[23:19] !== '0)
                    log_mismatch($sformatf("pad bits expected 0 got %b", m_axis_tdata[23:19]));
            end
        end
    end

    // Lookups on an empty cache: every class except hit, near-misses of patterns
    task automatic test_empty_cache();
        send_request(FUNC_LOOKUP, BCAST_MAC, 16'h0000);
        send_request(FUNC_LOOKUP, {MCAST6_PREFIX, 32'hFFFF_FFFF}, 16'h0000);
        send_request(FUNC_LOOKUP, {MCAST4_PREFIX, 24'h000000}, 16'h0000);
        send_request(FUNC_LOOKUP, LOCAL_MAC_BIT, 16'h0000);
        send_request(FUNC_LOOKUP, 48'h0, 16'hFFFF);
        send_request(FUNC_LOOKUP, 48'h01_00_5F_12_34_56, 16'h1234);
        send_request(FUNC_LOOKUP, 48'h33_34_00_00_00_01, 16'h0000);
        send_request(FUNC_LOOKUP, 48'hFF_FF_FF_FF_FF_FE, 16'h0000);
    endtask

    // Special addresses stored as plain OUIs still classify by pattern first
    task automatic test_special_inserts();
        send_request(FUNC_INSERT, BCAST_MAC, 16'hA5A5);
        send_request(FUNC_INSERT, {MCAST6_PREFIX, 32'h0000_0000}, 16'h5A5A);
        send_request(FUNC_INSERT, {MCAST4_PREFIX, 24'hFFFFFF}, 16'h0F0F);
        send_request(FUNC_INSERT, LOCAL_MAC_BIT, 16'hF0F0);
        send_request(FUNC_INSERT, 48'h0, 16'hFFFF);
        send_request(FUNC_INSERT, 48'h00_1B_2C_00_00_00, 16'h0000);
        send_request(FUNC_LOOKUP, BCAST_MAC, 16'h0000);
        send_request(FUNC_LOOKUP, {MCAST6_PREFIX, 32'h0000_0000}, 16'h0000);
        send_request(FUNC_LOOKUP, {MCAST4_PREFIX, 24'hFFFFFF}, 16'h0000);
        send_request(FUNC_LOOKUP, 48'h00_00_00_FF_FF_FF, 16'h0000);
        send_request(FUNC_LOOKUP, 48'h00_1B_2C_9A_BC_DE, 16'hFFFF);
        send_request(FUNC_LOOKUP, 48'h01_00_5F_00_00_00, 16'h0000);
    endtask

    // Same OUI twice: the older, lower entry answers
    task automatic test_duplicate_oui();
        send_request(FUNC_INSERT, 48'h00_50_C2_00_00_00, 16'h1111);
        send_request(FUNC_INSERT, 48'h00_50_C2_11_22_33, 16'h2222);
        send_request(FUNC_LOOKUP, 48'h00_50_C2_AB_CD_EF, 16'h0000);
        send_request(FUNC_LOOKUP, 48'hFD_FF_FF_FF_FF_FF, 16'h0000);
    endtask

    // Hold the output for a long stretch so the block backs up into its input
    task automatic test_output_backpressure();
        hold_len = 400;
        for (int n = 0; n < 10; n++) begin
            if (n % 2 == 0)
                send_request(FUNC_LOOKUP, {24'h0050C2, 24'($urandom)}, 16'($urandom));
            else
                send_request(FUNC_LOOKUP, random_mac(), 16'($urandom));
        end
    endtask

    // Mixed traffic over a pool of OUIs larger than the cache, so entries wrap
    task automatic test_random_traffic();
        logic [OUI_W-1:0] oui_pool [80];
        int pick;
        foreach (oui_pool[i]) begin
            oui_pool[i] = 24'($urandom);
            if ($urandom_range(0, 9) != 0)
                oui_pool[i][16 + LOCAL_BIT] = 1'b0;
        end
        for (int n = 0; n < 450; n++) begin
            steady = (n >= 200 && n < 280);
            pick   = $urandom_range(0, 99);
            if (pick < 30)
                send_request(FUNC_INSERT, {oui_pool[$urandom_range(0, 79)], 24'($urandom)},
                             16'($urandom));
            else if (pick < 33)
                send_request(FUNC_INSERT, random_mac(), 16'($urandom));
            else if (pick < 70)
                send_request(FUNC_LOOKUP, {oui_pool[$urandom_range(0, 79)], 24'($urandom)},
                             16'($urandom));
            else if (pick < 80) begin
                case ($urandom_range(0, 3))
                    0: send_request(FUNC_LOOKUP, BCAST_MAC, 16'($urandom));
                    1: send_request(FUNC_LOOKUP, {MCAST6_PREFIX, 32'($urandom)}, 16'($urandom));
                    2: send_request(FUNC_LOOKUP, {MCAST4_PREFIX, 24'($urandom)}, 16'($urandom));
                    default: send_request(FUNC_LOOKUP, random_mac() | LOCAL_MAC_BIT,
                                          16'($urandom));
                endcase
            end else
                send_request(FUNC_LOOKUP, random_mac(), 16'($urandom));
        end
        steady = 1'b0;
    endtask

    // Main sequence
    initial begin : main_seq
        int unsigned waited;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = FUNC_LOOKUP;
        steady         = 1'b0;
        hold_len       = 0;
        mismatch_count = 0;
        cache_fill     = 0;
        cache_wr_ptr   = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_cache();
        test_special_inserts();
        test_duplicate_oui();
        test_output_backpressure();
        test_random_traffic();
        s_axis_tvalid <= 1'b0;

        // drain, then give a trailing search time to show stray results
        waited = 0;
        while (pending_lookups.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (2 * ENTRIES + 10) @(posedge i_clk);
        if (pending_lookups.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", pending_lookups.size()));

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
